// ----- hw/rtl/gglay_pkg.sv -----
// Types, codes and constants shared by the glyph layout block and its checker.
package gglay_pkg;

   localparam int ORD_W   = 10;
   localparam int ADV_W   = 8;
   localparam int UNIT_W  = 16;
   localparam int SUM_W   = 20;
   localparam int LIMIT_W = 17;
   localparam int ORD_SPAN = 1 << ORD_W;

   localparam logic [SUM_W-1:0]   WIDTH_MAX   = 20'hFFFFF;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

   // Substitutes tried in order for a missing character.
   localparam logic [UNIT_W-1:0] FALLBACK_UNITS [3] = '{16'hFFFD, 16'h00A4, 16'h003F};

   // Control ranges: U+0001..U+0020 and U+007F..U+009F.
   localparam logic [UNIT_W-1:0] CTRL_LOW_LAST = 16'h0020;
   localparam logic [UNIT_W-1:0] DEL_FIRST     = 16'h007F;
   localparam logic [UNIT_W-1:0] C1_LAST       = 16'h009F;

   typedef enum logic [1:0] {
      OP_WRITE_MAP   = 2'd0,
      OP_WRITE_GLYPH = 2'd1,
      OP_LAYOUT      = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DIRECT     = 2'd0,
      STATUS_SUBST      = 2'd1,
      STATUS_BLANK      = 2'd2,
      STATUS_BLANK_OOR  = 2'd3
   } status_type;

   typedef enum logic {
      KIND_GLYPH = 1'b0,
      KIND_END   = 1'b1
   } kind_type;

   typedef enum logic {
      CSR_GUARD_ENABLE  = 1'b0,
      CSR_CHARMAP_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP_RD,
      ST_FB_RD,
      ST_GLYPH_RD,
      ST_END
   } state_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [UNIT_W-1:0] char_unit;
      logic [UNIT_W-1:0] map_index;
      logic [ORD_W-1:0]  map_ordinal;
      logic [ORD_W-1:0]  glyph_slot;
      logic              glyph_present;
      logic [ADV_W-1:0]  glyph_advance;
   } req_type;

   typedef struct packed {
      logic              result_kind;
      logic [ORD_W-1:0]  out_ordinal;
      logic [ADV_W-1:0]  out_advance;
      logic [SUM_W-1:0]  total_width;
      logic [1:0]        lookup_status;
   } rsp_type;

   typedef struct packed {
      logic               guard_enable;
      logic [LIMIT_W-1:0] charmap_limit;
   } cfg_type;

   typedef struct packed {
      logic       found;
      logic [1:0] idx;
   } fb_pick_type;

endpackage

// ----- hw/rtl/gglay_ram.sv -----
// Simple dual-port synchronous RAM with registered read data.
module gglay_ram
   #(parameter int DEPTH = 1024,
     parameter int WIDTH = 9,
     localparam int AW = $clog2(DEPTH))
   (input  logic             clock,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read so a stalled lookup keeps its value.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/gglay_ctrl.sv -----
// Lookup sequencer: clearing sweep, charmap and fallback reads, glyph read, width sum.
module gglay_ctrl
   import gglay_pkg::*;
   #(parameter int CHARMAP_DEPTH = 65536,
     parameter int GLYPH_COUNT   = 1024,
     localparam int GLYPH_DEPTH = (GLYPH_COUNT < ORD_SPAN) ? GLYPH_COUNT : ORD_SPAN,
     localparam int CA = $clog2(CHARMAP_DEPTH),
     localparam int GA = $clog2(GLYPH_DEPTH))
   (input  logic                  clock,
    input  logic                  reset,
    input  cfg_type               cfg,
    input  logic                  req_valid,
    input  req_type               req_data,
    output logic                  ready,
    output logic                  cm_we,
    output logic [CA-1:0]         cm_wr_addr,
    output logic [ORD_W-1:0]      cm_wr_data,
    output logic                  cm_re,
    output logic [CA-1:0]         cm_rd_addr,
    input  logic [ORD_W-1:0]      cm_rd_data,
    output logic                  gl_we,
    output logic [GA-1:0]         gl_wr_addr,
    output logic [ADV_W:0]        gl_wr_data,
    output logic                  gl_re,
    output logic [GA-1:0]         gl_rd_addr,
    input  logic [ADV_W:0]        gl_rd_data,
    input  logic                  slot_free,
    output logic                  emit_valid,
    output rsp_type               emit_data);

   localparam int CLEAR_LEN = (CHARMAP_DEPTH > GLYPH_DEPTH) ? CHARMAP_DEPTH : GLYPH_DEPTH;
   localparam int CW = $clog2(CLEAR_LEN);
   localparam logic [CW-1:0]      CLR_LAST = CW'(CLEAR_LEN - 1);
   localparam logic [LIMIT_W-1:0] CM_LIM   = LIMIT_W'(CHARMAP_DEPTH);
   localparam logic [LIMIT_W-1:0] GL_LIM   = LIMIT_W'(GLYPH_COUNT);
   localparam logic [LIMIT_W-1:0] GD_LIM   = LIMIT_W'(GLYPH_DEPTH);

   state_type           state_ff, state_in;
   logic [CW-1:0]       clr_cnt_ff, clr_cnt_in;
   logic [UNIT_W-1:0]   unit_ff, unit_in;
   logic                ob_ff, ob_in;
   logic [1:0]          fb_idx_ff, fb_idx_in;
   logic [ORD_W-1:0]    ix_ff, ix_in;
   logic [1:0]          status_ff, status_in;
   logic                glyph_ok_ff, glyph_ok_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;

   logic [LIMIT_W-1:0]  lim;
   logic [ORD_W-1:0]    ix_raw;
   logic                control;
   logic                missing;
   logic                go_glyph;
   logic [ORD_W-1:0]    sel_ix;
   logic [1:0]          sel_status;
   fb_pick_type         pick;
   logic [UNIT_W-1:0]   pick_unit;
   logic [SUM_W:0]      sum_wide;
   logic                hit;
   logic                finish;
   logic                accept;

   // First fallback at or after start that lies below the limit.
   function automatic fb_pick_type fb_pick(input logic [1:0] start,
                                           input logic [LIMIT_W-1:0] limit);
      fb_pick_type r;
      r = '0;
      for (int k = 2; k >= 0; k--) begin
         if (2'(k) >= start && {1'b0, FALLBACK_UNITS[k]} < limit) begin
            r.found = 1'b1;
            r.idx   = 2'(k);
         end
      end
      return r;
   endfunction

   assign lim = (cfg.charmap_limit > CM_LIM) ? CM_LIM : cfg.charmap_limit;

   assign ix_raw  = ob_ff ? '0 : cm_rd_data;
   assign control = (unit_ff <= CTRL_LOW_LAST) ||
                    (unit_ff >= DEL_FIRST && unit_ff <= C1_LAST);
   assign missing = (ix_raw == '0) && !control;
   assign hit     = glyph_ok_ff && gl_rd_data[ADV_W];
   assign sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(gl_rd_data[ADV_W-1:0]);

   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      unit_in     = unit_ff;
      ob_in       = ob_ff;
      fb_idx_in   = fb_idx_ff;
      ix_in       = ix_ff;
      status_in   = status_ff;
      glyph_ok_in = glyph_ok_ff;
      sum_in      = sum_ff;
      cm_we       = 1'b0;
      cm_wr_addr  = '0;
      cm_wr_data  = '0;
      cm_re       = 1'b0;
      cm_rd_addr  = '0;
      gl_we       = 1'b0;
      gl_wr_addr  = '0;
      gl_wr_data  = '0;
      gl_re       = 1'b0;
      gl_rd_addr  = '0;
      emit_valid  = 1'b0;
      emit_data   = '0;
      go_glyph    = 1'b0;
      sel_ix      = '0;
      sel_status  = STATUS_DIRECT;
      pick        = '0;
      pick_unit   = '0;
      finish      = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            cm_we      = (LIMIT_W'(clr_cnt_ff) < CM_LIM);
            cm_wr_addr = clr_cnt_ff[CA-1:0];
            gl_we      = (LIMIT_W'(clr_cnt_ff) < GD_LIM);
            gl_wr_addr = clr_cnt_ff[GA-1:0];
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
         end
         ST_MAP_RD: begin
            if (!missing) begin
               go_glyph   = 1'b1;
               sel_ix     = ix_raw;
               sel_status = STATUS_DIRECT;
            end else begin
               pick = cfg.guard_enable ? fb_pick(2'd0, lim) : '0;
               if (pick.found) begin
                  pick_unit  = FALLBACK_UNITS[pick.idx];
                  cm_re      = 1'b1;
                  cm_rd_addr = pick_unit[CA-1:0];
                  fb_idx_in  = pick.idx + 2'd1;
                  state_in   = ST_FB_RD;
               end else begin
                  go_glyph   = 1'b1;
                  sel_status = ob_ff ? STATUS_BLANK_OOR : STATUS_BLANK;
               end
            end
         end
         ST_FB_RD: begin
            if (cm_rd_data != '0) begin
               go_glyph   = 1'b1;
               sel_ix     = cm_rd_data;
               sel_status = STATUS_SUBST;
            end else begin
               pick = fb_pick(fb_idx_ff, lim);
               if (pick.found) begin
                  pick_unit  = FALLBACK_UNITS[pick.idx];
                  cm_re      = 1'b1;
                  cm_rd_addr = pick_unit[CA-1:0];
                  fb_idx_in  = pick.idx + 2'd1;
               end else begin
                  go_glyph   = 1'b1;
                  sel_status = ob_ff ? STATUS_BLANK_OOR : STATUS_BLANK;
               end
            end
         end
         ST_GLYPH_RD: begin
            // An absent glyph is dropped without touching the sum.
            if (!hit) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end else if (slot_free) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
               sum_in   = sum_wide[SUM_W] ? WIDTH_MAX : sum_wide[SUM_W-1:0];
               emit_valid              = 1'b1;
               emit_data.result_kind   = KIND_GLYPH;
               emit_data.out_ordinal   = ix_ff;
               emit_data.out_advance   = gl_rd_data[ADV_W-1:0];
               emit_data.total_width   = sum_in;
               emit_data.lookup_status = status_ff;
            end
         end
         ST_END: begin
            if (slot_free) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
               sum_in   = '0;
               emit_valid            = 1'b1;
               emit_data.result_kind = KIND_END;
               emit_data.total_width = sum_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (go_glyph) begin
         ix_in       = sel_ix;
         status_in   = sel_status;
         glyph_ok_in = {{(LIMIT_W-ORD_W){1'b0}}, sel_ix} < GL_LIM;
         gl_re       = glyph_ok_in;
         gl_rd_addr  = sel_ix[GA-1:0];
         state_in    = ST_GLYPH_RD;
      end

      ready  = (state_ff == ST_IDLE) || finish;
      accept = req_valid && ready;

      if (accept) begin
         case (req_data.op)
            OP_WRITE_MAP: begin
               cm_we      = ({1'b0, req_data.map_index} < CM_LIM);
               cm_wr_addr = req_data.map_index[CA-1:0];
               cm_wr_data = req_data.map_ordinal;
            end
            OP_WRITE_GLYPH: begin
               gl_we      = ({{(LIMIT_W-ORD_W){1'b0}}, req_data.glyph_slot} < GL_LIM);
               gl_wr_addr = req_data.glyph_slot[GA-1:0];
               gl_wr_data = {req_data.glyph_present, req_data.glyph_advance};
            end
            OP_LAYOUT: begin
               if (req_data.char_unit == '0) begin
                  state_in = ST_END;
               end else begin
                  unit_in    = req_data.char_unit;
                  ob_in      = ({1'b0, req_data.char_unit} >= lim);
                  cm_re      = 1'b1;
                  cm_rd_addr = req_data.char_unit[CA-1:0];
                  state_in   = ST_MAP_RD;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
         sum_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         sum_ff     <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      unit_ff     <= unit_in;
      ob_ff       <= ob_in;
      fb_idx_ff   <= fb_idx_in;
      ix_ff       <= ix_in;
      status_ff   <= status_in;
      glyph_ok_ff <= glyph_ok_in;
   end

endmodule

// ----- hw/rtl/guarded_glyph_layout.sv -----
// Glyph lookup for text layout with a charmap bounds guard and fallback substitution.
//
// After reset the block sweeps both stores to zero, one entry per cycle, over
// max(CHARMAP_DEPTH, min(GLYPH_COUNT, 1024)) addresses (65536 with the defaults); it
// stalls its input during that sweep while register writes still land. Charmap
// and glyph writes are issued when the item is accepted. Laying out a mapped
// code unit takes one read of the charmap memory, then one read of the glyph
// memory. A missing character under the guard costs one more charmap read for
// each fallback tried, up to three. A finished result waits in an output
// register, so the next item is taken while the consumer stalls, until a
// second result is ready to leave.
module guarded_glyph_layout
   import gglay_pkg::*;
   #(parameter int CHARMAP_DEPTH = 65536,
     parameter int GLYPH_COUNT   = 1024)
   (input  logic               clock,
    input  logic               reset,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_type            req_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_type            rsp_data,
    input  logic               csr_we,
    input  logic               csr_index,
    input  logic [LIMIT_W-1:0] csr_wdata);

   localparam int GLYPH_DEPTH = (GLYPH_COUNT < ORD_SPAN) ? GLYPH_COUNT : ORD_SPAN;
   localparam int CA = $clog2(CHARMAP_DEPTH);
   localparam int GA = $clog2(GLYPH_DEPTH);

   logic               guard_enable_ff, guard_enable_in;
   logic [LIMIT_W-1:0] charmap_limit_ff, charmap_limit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   cfg_type            cfg;

   logic               ready;
   logic               slot_free;
   logic               emit_valid;
   rsp_type            emit_data;

   logic               cm_we, cm_re, gl_we, gl_re;
   logic [CA-1:0]      cm_wr_addr, cm_rd_addr;
   logic [ORD_W-1:0]   cm_wr_data, cm_rd_data;
   logic [GA-1:0]      gl_wr_addr, gl_rd_addr;
   logic [ADV_W:0]     gl_wr_data, gl_rd_data;

   always_comb begin
      guard_enable_in  = guard_enable_ff;
      charmap_limit_in = charmap_limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GUARD_ENABLE:  guard_enable_in  = csr_wdata[0];
            CSR_CHARMAP_LIMIT: charmap_limit_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg.guard_enable  = guard_enable_ff;
   assign cfg.charmap_limit = charmap_limit_ff;

   // The output register frees up in the same cycle its transfer completes.
   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = emit_valid || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = emit_valid ? emit_data : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         guard_enable_ff  <= 1'b1;
         charmap_limit_ff <= LIMIT_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         guard_enable_ff  <= guard_enable_in;
         charmap_limit_ff <= charmap_limit_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = !ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   gglay_ram #(.DEPTH(CHARMAP_DEPTH), .WIDTH(ORD_W)) u_charmap (
      .clock   (clock),
      .wr_en   (cm_we),
      .wr_addr (cm_wr_addr),
      .wr_data (cm_wr_data),
      .rd_en   (cm_re),
      .rd_addr (cm_rd_addr),
      .rd_data (cm_rd_data));

   gglay_ram #(.DEPTH(GLYPH_DEPTH), .WIDTH(ADV_W + 1)) u_glyphs (
      .clock   (clock),
      .wr_en   (gl_we),
      .wr_addr (gl_wr_addr),
      .wr_data (gl_wr_data),
      .rd_en   (gl_re),
      .rd_addr (gl_rd_addr),
      .rd_data (gl_rd_data));

   gglay_ctrl #(.CHARMAP_DEPTH(CHARMAP_DEPTH), .GLYPH_COUNT(GLYPH_COUNT)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .ready      (ready),
      .cm_we      (cm_we),
      .cm_wr_addr (cm_wr_addr),
      .cm_wr_data (cm_wr_data),
      .cm_re      (cm_re),
      .cm_rd_addr (cm_rd_addr),
      .cm_rd_data (cm_rd_data),
      .gl_we      (gl_we),
      .gl_wr_addr (gl_wr_addr),
      .gl_wr_data (gl_wr_data),
      .gl_re      (gl_re),
      .gl_rd_addr (gl_rd_addr),
      .gl_rd_data (gl_rd_data),
      .slot_free  (slot_free),
      .emit_valid (emit_valid),
      .emit_data  (emit_data));

endmodule

// ----- hw/rtl/gglay_checker.sv -----
// Port-level checks for the glyph layout block, bound to its top level.
module gglay_checker
   import gglay_pkg::*;
   (input logic    clock,
    input logic    reset,
    input logic    req_stall,
    input logic    rsp_valid,
    input logic    rsp_stall,
    input rsp_type rsp_data);

   // The store clearing sweep follows every reset, so no transfer is taken right after it.
   assert property (@(posedge clock) reset |=> req_stall)
      else $error("input accepted right after reset");

   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result dropped or changed");

   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_data.result_kind == KIND_END |->
                    rsp_data.out_ordinal == '0 && rsp_data.out_advance == '0 &&
                    rsp_data.lookup_status == STATUS_DIRECT)
      else $error("end-of-string result carries glyph fields");

   // The sum after adding a glyph never falls below that glyph's width.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_data.result_kind == KIND_GLYPH |->
                    rsp_data.total_width >= SUM_W'(rsp_data.out_advance))
      else $error("glyph total width below its advance");

endmodule

bind guarded_glyph_layout gglay_checker u_gglay_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data));

// ----- sim/tb.sv -----
// Self-checking testbench for the guarded glyph layout block.
`timescale 1ns / 1ps

module tb;
   import gglay_pkg::*;

   localparam int CHARMAP_DEPTH = 65536;
   localparam int GLYPH_COUNT   = 1024;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [UNIT_W-1:0] MAPPED_BASE = 16'h0040;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_type            req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_data;
   logic               csr_we = 1'b0;
   logic               csr_index = CSR_GUARD_ENABLE;
   logic [LIMIT_W-1:0] csr_wdata = '0;

   // Shadow copy of the block's state and registers.
   bit [ORD_W-1:0]   charmap_copy [CHARMAP_DEPTH];
   bit [ADV_W:0]     glyph_copy [GLYPH_COUNT];
   bit [SUM_W-1:0]   width_acc = '0;
   bit               guard_on = 1'b1;
   bit [LIMIT_W-1:0] limit_reg = LIMIT_RESET;

   rsp_type pending_layout_q [$];
   int      mismatch_count = 0;
   bit      no_idle = 1'b0;

   guarded_glyph_layout #(.CHARMAP_DEPTH(CHARMAP_DEPTH), .GLYPH_COUNT(GLYPH_COUNT)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata));

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Works out what one accepted item should produce and updates the shadow state.
   function automatic void predict_layout(input req_type item);
      logic [LIMIT_W-1:0] lim;
      logic [ORD_W-1:0]   ord;
      logic               oob;
      logic               ctrl;
      logic [ADV_W:0]     rec;
      logic [SUM_W:0]     grown;
      status_type         st;
      rsp_type            r;
      case (item.op)
         OP_WRITE_MAP: begin
            if (item.map_index < CHARMAP_DEPTH)
               charmap_copy[item.map_index] = item.map_ordinal;
         end
         OP_WRITE_GLYPH: begin
            if (item.glyph_slot < GLYPH_COUNT)
               glyph_copy[item.glyph_slot] = {item.glyph_present, item.glyph_advance};
         end
         OP_LAYOUT: begin
            if (item.char_unit == '0) begin
               r = '0;
               r.result_kind = KIND_END;
               r.total_width = width_acc;
               r.lookup_status = STATUS_DIRECT;
               pending_layout_q.push_back(r);
               width_acc = '0;
               return;
            end
            lim = (limit_reg > CHARMAP_DEPTH) ? LIMIT_W'(CHARMAP_DEPTH) : limit_reg;
            oob = ({1'b0, item.char_unit} >= lim);
            ord = oob ? '0 : charmap_copy[item.char_unit];
            ctrl = (item.char_unit <= CTRL_LOW_LAST) ||
                   (item.char_unit >= DEL_FIRST && item.char_unit <= C1_LAST);
            st = STATUS_DIRECT;
            if (ord == '0 && !ctrl) begin
               if (guard_on) begin
                  for (int i = 0; i < 3; i++) begin
                     if (ord == '0 && {1'b0, FALLBACK_UNITS[i]} < lim &&
                         charmap_copy[FALLBACK_UNITS[i]] != '0)
                        ord = charmap_copy[FALLBACK_UNITS[i]];
                  end
               end
               if (ord != '0)
                  st = STATUS_SUBST;
               else
                  st = oob ? STATUS_BLANK_OOR : STATUS_BLANK;
            end
            if (ord >= GLYPH_COUNT)
               return;
            rec = glyph_copy[ord];
            if (!rec[ADV_W])
               return;
            grown = {1'b0, width_acc} + (SUM_W + 1)'(rec[ADV_W-1:0]);
            width_acc = (grown > WIDTH_MAX) ? WIDTH_MAX : grown[SUM_W-1:0];
            r.result_kind = KIND_GLYPH;
            r.out_ordinal = ord;
            r.out_advance = rec[ADV_W-1:0];
            r.total_width = width_acc;
            r.lookup_status = st;
            pending_layout_q.push_back(r);
         end
         default: ;
      endcase
   endfunction

   // Result side: random back-pressure, then compare each transfer in order.
   always @(posedge clock)
      rsp_stall <= !no_idle && ($urandom_range(0, 99) < 26);

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_layout_q.size() == 0) begin
            $error("result transfer with no result pending");
            mismatch_count++;
         end else begin
            want = pending_layout_q.pop_front();
            check_field("result_kind", 32'(want.result_kind), 32'(rsp_data.result_kind));
            check_field("out_ordinal", 32'(want.out_ordinal), 32'(rsp_data.out_ordinal));
            check_field("out_advance", 32'(want.out_advance), 32'(rsp_data.out_advance));
            check_field("total_width", 32'(want.total_width), 32'(rsp_data.total_width));
            check_field("lookup_status", 32'(want.lookup_status),
                        32'(rsp_data.lookup_status));
         end
      end
   end

   // Request side.
   function automatic req_type random_fill();
      req_type it;
      it.op = 2'($urandom_range(0, 3));
      it.char_unit = 16'($urandom);
      it.map_index = 16'($urandom);
      it.map_ordinal = 10'($urandom);
      it.glyph_slot = 10'($urandom);
      it.glyph_present = 1'($urandom);
      it.glyph_advance = 8'($urandom);
      return it;
   endfunction

   task automatic send_item(input req_type item);
      while (!no_idle && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_layout(item);
   endtask

   task automatic put_map(input logic [UNIT_W-1:0] idx, input logic [ORD_W-1:0] ord);
      req_type it;
      it = random_fill();
      it.op = OP_WRITE_MAP;
      it.map_index = idx;
      it.map_ordinal = ord;
      send_item(it);
   endtask

   task automatic put_glyph(input logic [ORD_W-1:0] slot, input logic present,
                            input logic [ADV_W-1:0] adv);
      req_type it;
      it = random_fill();
      it.op = OP_WRITE_GLYPH;
      it.glyph_slot = slot;
      it.glyph_present = present;
      it.glyph_advance = adv;
      send_item(it);
   endtask

   task automatic lay_out(input logic [UNIT_W-1:0] unit);
      req_type it;
      it = random_fill();
      it.op = OP_LAYOUT;
      it.char_unit = unit;
      send_item(it);
   endtask

   // An item may finish without a result, so the wait goes on past the point where the queue drains.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_layout_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic apply_config(input bit guard, input logic [LIMIT_W-1:0] limit);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= CSR_GUARD_ENABLE;
      csr_wdata <= {16'($urandom), guard};
      @(posedge clock);
      csr_index <= CSR_CHARMAP_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we <= 1'b0;
      guard_on = guard;
      limit_reg = limit;
   endtask

   // Direct hits, controls, blanks, fallback order and ignored opcodes.
   task automatic test_directed_lookup();
      req_type it;
      put_map(16'h0041, 10'd5);
      put_glyph(10'd5, 1'b1, 8'd255);
      put_map(16'hFFFF, 10'd1023);
      put_glyph(10'd1023, 1'b1, 8'd0);
      put_glyph(10'd0, 1'b1, 8'd7);
      lay_out(16'h0041);
      lay_out(16'hFFFF);
      lay_out(16'h0001);
      lay_out(16'h0020);
      lay_out(16'h007F);
      lay_out(16'h009F);
      lay_out(16'h0042);
      put_map(16'h003F, 10'd3);
      put_glyph(10'd3, 1'b1, 8'd1);
      lay_out(16'h0042);
      put_map(16'h00A4, 10'd4);
      put_glyph(10'd4, 1'b1, 8'd2);
      lay_out(16'h0043);
      // The first fallback wins even when its glyph is absent, so this is skipped.
      put_map(16'hFFFD, 10'd6);
      put_glyph(10'd6, 1'b0, 8'd99);
      lay_out(16'h0044);
      it = random_fill();
      it.op = OP_UNUSED;
      send_item(it);
      lay_out(16'h0000);
   endtask

   // Charmap limit edges, including zero and values above the charmap depth.
   task automatic test_limit_guard();
      apply_config(1'b1, 17'd257);
      lay_out(16'hFFFF);
      apply_config(1'b0, 17'd257);
      lay_out(16'hFFFF);
      lay_out(16'h0042);
      apply_config(1'b1, 17'd0);
      lay_out(16'h0041);
      lay_out(16'h0005);
      apply_config(1'b1, 17'h1FFFF);
      lay_out(16'hFFFF);
      apply_config(1'b1, LIMIT_RESET);
      lay_out(16'h0000);
   endtask

   // A long run of full-width glyphs with no idling on either side.
   task automatic test_full_width_run();
      no_idle = 1'b1;
      put_glyph(10'd9, 1'b1, 8'd255);
      put_map(16'h0100, 10'd9);
      repeat (100) lay_out(16'h0100);
      lay_out(16'h0000);
      no_idle = 1'b0;
   endtask

   function automatic req_type random_item();
      req_type it;
      int pick;
      it = random_fill();
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         it.op = OP_WRITE_MAP;
         pick = $urandom_range(0, 99);
         if (pick < 50)
            it.map_index = 16'(MAPPED_BASE + $urandom_range(0, 31));
         else if (pick < 65)
            it.map_index = FALLBACK_UNITS[$urandom_range(0, 2)];
         pick = $urandom_range(0, 99);
         if (pick < 70)
            it.map_ordinal = 10'($urandom_range(0, 31));
         else if (pick < 80)
            it.map_ordinal = '0;
      end else if (pick < 40) begin
         it.op = OP_WRITE_GLYPH;
         if ($urandom_range(0, 99) < 70)
            it.glyph_slot = 10'($urandom_range(0, 31));
         it.glyph_present = ($urandom_range(0, 99) < 80);
      end else if (pick < 97) begin
         it.op = OP_LAYOUT;
         pick = $urandom_range(0, 99);
         if (pick < 10)
            it.char_unit = '0;
         else if (pick < 55)
            it.char_unit = 16'(MAPPED_BASE + $urandom_range(0, 31));
         else if (pick < 65)
            it.char_unit = FALLBACK_UNITS[$urandom_range(0, 2)];
         else if (pick < 70)
            it.char_unit = 16'($urandom_range(1, 32));
         else if (pick < 75)
            it.char_unit = 16'($urandom_range(16'h7F, 16'h9F));
      end else begin
         it.op = OP_UNUSED;
      end
      return it;
   endfunction

   task automatic test_random_phases();
      bit               guards [7] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
      logic [LIMIT_W-1:0] limits [7] = '{17'd65536, 17'd65536, 17'd257, 17'd257,
                                        17'd1, 17'd165, 17'd64};
      for (int p = 0; p < 7; p++) begin
         apply_config(guards[p], limits[p]);
         repeat (138) send_item(random_item());
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_lookup();
      test_limit_guard();
      test_full_width_run();
      test_random_phases();
      req_valid <= 1'b0;
      while (pending_layout_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
